// ===== src/rlrd_pkg.sv =====
// Shared types and constants of the raster line run decoder.
`default_nettype none

package rlrd_pkg;

  // Fixed sizes of the decoder
  localparam int LINE_MAX         = 128;
  localparam int PATTERN_MAX      = 16;
  localparam int BYTES_PER_RESULT = 8;

  // Command byte codes and masks
  localparam logic [7:0] CODE_ZERO  = 8'h00;
  localparam logic [7:0] CODE_LIT   = 8'h80;
  localparam logic [6:0] COUNT_MASK = 7'h7f;
  localparam logic [7:0] FILL_ONES  = 8'hff;

  // Parser phases
  typedef enum logic [2:0] {
    PH_CMD,
    PH_ZERO,
    PH_PAT,
    PH_LITC,
    PH_LIT,
    PH_FLAG,
    PH_CNT
  } phase_t;

  // Expander states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SOLID,
    BK_PAT
  } bstate_t;

  // Kinds of classified command
  typedef enum logic [1:0] {
    CMD_SOLID,
    CMD_PAT_BYTE,
    CMD_LIT,
    CMD_HDR
  } cmd_kind_t;

  // One classified command from parser to expander
  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data;
    logic        last;
    logic [3:0]  idx;
    logic [7:0]  run;
  } cmd_t;

  // One result item
  typedef struct packed {
    logic [63:0] bytes;
    logic [3:0]  count;
    logic        line_end;
    logic [7:0]  line_repeat;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

// ===== src/rlrd_fifo.sv =====
// Small register queue used for commands and for results.
`default_nettype none

module rlrd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rdata,
  output logic                  full,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rdata = mem[rptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (do_rd) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

  // Store written entries
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== src/rlrd_front.sv =====
// Stream parser: classifies compressed bytes and turns them into commands.
`default_nettype none

module rlrd_front import rlrd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire logic [7:0] in_byte,
  input  wire logic [4:0] pattern_length,
  input  wire logic       q_full,
  output logic            full,
  output logic            cmd_push,
  output cmd_t            cmd
);

  phase_t     phase, phase_next;
  logic [7:0] left, left_next;
  logic [3:0] fill, fill_next;
  logic [4:0] pat_len, pat_len_next;
  logic [7:0] run, run_next;
  logic       accept;
  logic [4:0] pl_clamped;
  logic       pat_last;

  assign full   = q_full;
  assign accept = push && !q_full;

  // Clamp the pattern length register into range
  always_comb begin
    if (pattern_length == 5'd0) begin
      pl_clamped = 5'd1;
    end else if (pattern_length > 5'(PATTERN_MAX)) begin
      pl_clamped = 5'(PATTERN_MAX);
    end else begin
      pl_clamped = pattern_length;
    end
  end

  assign pat_last = (({1'b0, fill} + 5'd1) == pat_len);

  // Hold parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_CMD;
      left    <= '0;
      fill    <= '0;
      pat_len <= 5'd1;
      run     <= '0;
    end else begin
      phase   <= phase_next;
      left    <= left_next;
      fill    <= fill_next;
      pat_len <= pat_len_next;
      run     <= run_next;
    end
  end

  // Classify the accepted byte and step the parser
  always_comb begin
    phase_next   = phase;
    left_next    = left;
    fill_next    = fill;
    pat_len_next = pat_len;
    run_next     = run;
    cmd_push     = 1'b0;
    cmd.kind     = CMD_SOLID;
    cmd.data     = in_byte;
    cmd.last     = 1'b0;
    cmd.idx      = fill;
    cmd.run      = run;
    if (accept) begin
      unique case (phase)
        PH_CMD: begin
          if (in_byte == CODE_ZERO) begin
            phase_next = PH_ZERO;
          end else if (in_byte == CODE_LIT) begin
            phase_next = PH_LITC;
          end else begin
            cmd_push = 1'b1;
            cmd.kind = CMD_SOLID;
          end
        end
        PH_ZERO: begin
          if (in_byte == CODE_ZERO) begin
            phase_next = PH_FLAG;
          end else begin
            pat_len_next = pl_clamped;
            run_next     = in_byte;
            fill_next    = '0;
            phase_next   = PH_PAT;
          end
        end
        PH_PAT: begin
          cmd_push  = 1'b1;
          cmd.kind  = CMD_PAT_BYTE;
          cmd.last  = pat_last;
          fill_next = fill + 4'd1;
          if (pat_last) begin
            phase_next = PH_CMD;
          end
        end
        PH_LITC: begin
          left_next  = in_byte;
          phase_next = (in_byte == 8'd0) ? PH_CMD : PH_LIT;
        end
        PH_LIT: begin
          cmd_push  = 1'b1;
          cmd.kind  = CMD_LIT;
          cmd.last  = (left == 8'd1);
          left_next = left - 8'd1;
          if (left == 8'd1) begin
            phase_next = PH_CMD;
          end
        end
        PH_FLAG: begin
          phase_next = PH_CNT;
        end
        PH_CNT: begin
          cmd_push   = 1'b1;
          cmd.kind   = CMD_HDR;
          phase_next = PH_CMD;
        end
        default: begin
          phase_next = PH_CMD;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/rlrd_back.sv =====
// Expander: carries out commands, tracks the line and packs result items.
`default_nettype none

module rlrd_back import rlrd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cmd_valid,
  input  wire cmd_t       cmd,
  input  wire logic [7:0] line_bytes,
  input  wire logic       res_full,
  output logic            cmd_pop,
  output logic            res_push,
  output res_t            res
);

  bstate_t    state, state_next;
  logic [7:0] pos, pos_next;
  logic [7:0] pend, pend_next;
  logic       dropping, dropping_next;
  logic [6:0] solid_left, solid_left_next;
  logic [7:0] fill_byte, fill_byte_next;
  logic [7:0] run_left, run_left_next;
  logic [3:0] pat_j, pat_j_next;
  logic [4:0] pat_len, pat_len_next;
  logic [3:0] pack_cnt, pack_cnt_next;
  logic [7:0] pbuf [BYTES_PER_RESULT];
  logic [7:0] pbuf_next [BYTES_PER_RESULT];
  logic [7:0] pstore [PATTERN_MAX];
  logic       pstore_we;

  logic [7:0] lim;
  logic [7:0] room;
  logic [7:0] chunk;
  logic [7:0] pos_inc;
  logic [7:0] pos_sum;
  logic       done;
  logic [7:0] pat_byte;
  logic       pat_wrap;
  logic [3:0] pack_inc;

  // Clamp the line length register into range
  always_comb begin
    if (line_bytes == 8'd0) begin
      lim = 8'd1;
    end else if (line_bytes > 8'(LINE_MAX)) begin
      lim = 8'(LINE_MAX);
    end else begin
      lim = line_bytes;
    end
  end

  // Size the next solid chunk: limited by result width, run and line room
  always_comb begin
    room  = (lim > pos) ? lim - pos : 8'd1;
    chunk = 8'(BYTES_PER_RESULT);
    if ({1'b0, solid_left} < chunk) begin
      chunk = {1'b0, solid_left};
    end
    if (room < chunk) begin
      chunk = room;
    end
  end

  assign pat_byte = pstore[pat_j];
  assign pat_wrap = ({1'b0, pat_j} == (pat_len - 5'd1));
  assign pack_inc = pack_cnt + 4'd1;
  assign pos_inc  = (state == BK_SOLID) ? chunk : 8'd1;
  assign pos_sum  = pos + pos_inc;
  assign done     = (pos_sum >= lim);

  // Hold expander state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_IDLE;
      pos      <= '0;
      pend     <= 8'd1;
      dropping <= 1'b0;
    end else begin
      state    <= state_next;
      pos      <= pos_next;
      pend     <= pend_next;
      dropping <= dropping_next;
    end
  end

  // Hold run counters and the pack buffer
  always_ff @(posedge clk) begin
    solid_left <= solid_left_next;
    fill_byte  <= fill_byte_next;
    run_left   <= run_left_next;
    pat_j      <= pat_j_next;
    pat_len    <= pat_len_next;
    pack_cnt   <= pack_cnt_next;
    pbuf       <= pbuf_next;
  end

  // Write the pattern register file
  always_ff @(posedge clk) begin
    if (pstore_we) begin
      pstore[cmd.idx] <= cmd.data;
    end
  end

  // Step the expander and form results
  always_comb begin
    state_next      = state;
    pos_next        = pos;
    pend_next       = pend;
    dropping_next   = dropping;
    solid_left_next = solid_left;
    fill_byte_next  = fill_byte;
    run_left_next   = run_left;
    pat_j_next      = pat_j;
    pat_len_next    = pat_len;
    pack_cnt_next   = pack_cnt;
    pbuf_next       = pbuf;
    pstore_we       = 1'b0;
    cmd_pop         = 1'b0;
    res_push        = 1'b0;
    res.bytes       = '0;
    res.count       = '0;
    res.line_end    = 1'b0;
    res.line_repeat = '0;
    res.last        = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.kind)
            CMD_HDR: begin
              cmd_pop = 1'b1;
              if (pos == 8'd0) begin
                pend_next = (cmd.data == 8'd0) ? 8'd1 : cmd.data;
              end
            end
            CMD_PAT_BYTE: begin
              cmd_pop   = 1'b1;
              pstore_we = 1'b1;
              if (cmd.last) begin
                run_left_next = cmd.run;
                pat_len_next  = {1'b0, cmd.idx} + 5'd1;
                pat_j_next    = '0;
                pack_cnt_next = '0;
                for (int k = 0; k < BYTES_PER_RESULT; k++) begin
                  pbuf_next[k] = '0;
                end
                state_next = BK_PAT;
              end
            end
            CMD_SOLID: begin
              cmd_pop         = 1'b1;
              solid_left_next = cmd.data[6:0] & COUNT_MASK;
              fill_byte_next  = cmd.data[7] ? FILL_ONES : 8'h00;
              state_next      = BK_SOLID;
            end
            CMD_LIT: begin
              if (dropping) begin
                // drop literal bytes past the line end
                cmd_pop = 1'b1;
                if (cmd.last) begin
                  dropping_next = 1'b0;
                end
              end else if (!res_full) begin
                cmd_pop          = 1'b1;
                res_push         = 1'b1;
                res.bytes[7:0]   = cmd.data;
                res.count        = 4'd1;
                res.last         = 1'b1;
                pos_next         = pos_sum;
                if (done) begin
                  res.line_end    = 1'b1;
                  res.line_repeat = pend;
                  pos_next        = '0;
                  pend_next       = 8'd1;
                  dropping_next   = !cmd.last;
                end
              end
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      BK_SOLID: begin
        if (!res_full) begin
          res_push = 1'b1;
          for (int k = 0; k < BYTES_PER_RESULT; k++) begin
            res.bytes[8*k +: 8] = (8'(k) < chunk) ? fill_byte : 8'h00;
          end
          res.count       = chunk[3:0];
          solid_left_next = solid_left - chunk[6:0];
          pos_next        = pos_sum;
          res.last        = done || ({1'b0, solid_left} == chunk);
          if (done) begin
            res.line_end    = 1'b1;
            res.line_repeat = pend;
            pos_next        = '0;
            pend_next       = 8'd1;
          end
          if (res.last) begin
            state_next = BK_IDLE;
          end
        end
      end
      BK_PAT: begin
        if (!res_full) begin
          // insert one pattern byte, emit when full or at the end
          pbuf_next[pack_cnt[2:0]] = pat_byte;
          for (int k = 0; k < BYTES_PER_RESULT; k++) begin
            res.bytes[8*k +: 8] = pbuf_next[k];
          end
          res.count     = pack_inc;
          res.last      = done || (pat_wrap && run_left == 8'd1);
          res_push      = res.last || (pack_inc == 4'(BYTES_PER_RESULT));
          pack_cnt_next = pack_inc;
          pos_next      = pos_sum;
          if (res_push) begin
            pack_cnt_next = '0;
            for (int k = 0; k < BYTES_PER_RESULT; k++) begin
              pbuf_next[k] = '0;
            end
          end
          if (pat_wrap) begin
            pat_j_next    = '0;
            run_left_next = run_left - 8'd1;
          end else begin
            pat_j_next = pat_j + 4'd1;
          end
          if (done) begin
            res.line_end    = 1'b1;
            res.line_repeat = pend;
            pos_next        = '0;
            pend_next       = 8'd1;
          end
          if (res.last) begin
            state_next = BK_IDLE;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/raster_line_run_decoder_unit.sv =====
// Top level of the raster line run decoder: config registers, queues, parser, expander.
`default_nettype none

// Decodes a run-length compressed bitplane stream pushed in one byte per
// cycle. The parser takes one byte each cycle while its command queue has
// room; bytes that only set up a command (0x00, 0x80, literal and pattern
// run counts, header flags) leave nothing for the expander, while a header
// count becomes a command that sets the repeat count of a line not yet
// begun. The expander sets the output rate: a literal byte gives one result,
// a solid run is loaded and then gives up to eight bytes per cycle (one
// result per cycle) while the result queue has room, and a pattern run
// first stores each pattern byte and then reads its pattern register file
// one byte per cycle while the result queue has room, so a pattern run of
// n clipped bytes yields ceil(n/8) results. Each result carries up to eight
// bytes, first byte in the low bits; line_end marks the result that fills
// line_bytes bytes and line_repeat gives the repeat count of that line.
// Results wait in an output queue of RES_DEPTH entries, so input keeps
// flowing while a result waits to be popped. Registers: line_bytes at byte
// address 0, pattern_length at byte address 4; write only while idle.
module raster_line_run_decoder_unit import rlrd_pkg::*; #(
  parameter int CMD_DEPTH = 4,
  parameter int RES_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // byte stream
  input  wire logic        push,
  input  wire logic [7:0]  in_byte,
  output logic             full,
  // results
  input  wire logic        pop,
  output logic             empty,
  output logic [63:0]      out_bytes,
  output logic [3:0]       byte_count,
  output logic             line_end,
  output logic [7:0]       line_repeat,
  output logic             last_of_run,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic REG_LINE_BYTES = 1'b0;
  localparam logic REG_PAT_LEN    = 1'b1;

  logic [7:0] line_bytes;
  logic [4:0] pattern_length;
  logic       cfg_wr;

  logic       cmd_push;
  cmd_t       cmd_in;
  logic       cmd_full;
  logic       cmd_empty;
  logic       cmd_pop;
  logic [$bits(cmd_t)-1:0] cmd_rdata;
  cmd_t       cmd_head;

  logic       res_push;
  res_t       res_in;
  logic       res_full;
  logic [$bits(res_t)-1:0] res_rdata;
  res_t       res_head;

  // Write configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_bytes     <= 8'd80;
      pattern_length <= 5'd2;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_LINE_BYTES: line_bytes     <= pwdata[7:0];
        REG_PAT_LEN:    pattern_length <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    unique case (paddr[2])
      REG_LINE_BYTES: prdata = {24'd0, line_bytes};
      REG_PAT_LEN:    prdata = {27'd0, pattern_length};
      default:        prdata = '0;
    endcase
  end

  rlrd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .in_byte        (in_byte),
    .pattern_length (pattern_length),
    .q_full         (cmd_full),
    .full           (full),
    .cmd_push       (cmd_push),
    .cmd            (cmd_in)
  );

  rlrd_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .wr_en (cmd_push),
    .wdata (cmd_in),
    .rd_en (cmd_pop),
    .rdata (cmd_rdata),
    .full  (cmd_full),
    .empty (cmd_empty)
  );

  assign cmd_head = cmd_t'(cmd_rdata);

  rlrd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (!cmd_empty),
    .cmd        (cmd_head),
    .line_bytes (line_bytes),
    .res_full   (res_full),
    .cmd_pop    (cmd_pop),
    .res_push   (res_push),
    .res        (res_in)
  );

  rlrd_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .wr_en (res_push),
    .wdata (res_in),
    .rd_en (pop),
    .rdata (res_rdata),
    .full  (res_full),
    .empty (empty)
  );

  // Drive result ports from the queue head
  assign res_head    = res_t'(res_rdata);
  assign out_bytes   = res_head.bytes;
  assign byte_count  = res_head.count;
  assign line_end    = res_head.line_end;
  assign line_repeat = res_head.line_repeat;
  assign last_of_run = res_head.last;

  // Expander never writes a full result queue
  a_res_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result written into full queue");

  // Parser never writes a full command queue
  a_cmd_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> !cmd_full)
    else $error("command written into full queue");

  // A line end closes the run of its input byte
  a_line_end_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && line_end) |-> last_of_run)
    else $error("line end on a result that is not last");

  // Repeat count is present exactly on line ends
  a_repeat_on_end: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (line_end == (line_repeat != 8'd0)))
    else $error("line repeat does not match line end");

endmodule

`default_nettype wire
